FILE: sv/tmenc_pkg.sv
package tmenc_pkg;

    localparam int MAX_PENDING = 15;
    localparam int PEND_W      = 4;
    localparam int CODE_LEN_W  = 3;
    localparam int CODE_BITS_W = 5;
    localparam int NUM_CODES   = 36;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = 1;
    localparam int FIFO_CNT_W  = 2;

    typedef enum logic [2:0] {
        SYM_DOT   = 3'd0,
        SYM_DASH  = 3'd1,
        SYM_SLASH = 3'd2,
        SYM_GAP   = 3'd3,
        SYM_END   = 3'd4
    } sym_t;

    // One queued job: held space pairs, joining gap, code, end marker.
    typedef struct packed {
        logic [PEND_W-1:0]      pairs;
        logic                   gap;
        logic [CODE_LEN_W-1:0]  len;
        logic [CODE_BITS_W-1:0] bits;
        logic                   eop;
    } job_t;

    typedef struct packed {
        logic [CODE_LEN_W-1:0]  len;
        logic [CODE_BITS_W-1:0] bits;
    } code_t;

    // {length, elements left-aligned, first element in bit 4, dash = 1}
    localparam code_t CODE_ROM [NUM_CODES] = '{
        '{3'd2, 5'b01000}, '{3'd4, 5'b10000}, '{3'd4, 5'b10100}, '{3'd3, 5'b10000},
        '{3'd1, 5'b00000}, '{3'd4, 5'b00100}, '{3'd3, 5'b11000}, '{3'd4, 5'b00000},
        '{3'd2, 5'b00000}, '{3'd4, 5'b01110}, '{3'd3, 5'b10100}, '{3'd4, 5'b01000},
        '{3'd2, 5'b11000}, '{3'd2, 5'b10000}, '{3'd3, 5'b11100}, '{3'd4, 5'b01100},
        '{3'd4, 5'b11010}, '{3'd3, 5'b01000}, '{3'd3, 5'b00000}, '{3'd1, 5'b10000},
        '{3'd3, 5'b00100}, '{3'd4, 5'b00010}, '{3'd3, 5'b01100}, '{3'd4, 5'b10010},
        '{3'd4, 5'b10110}, '{3'd4, 5'b11000},
        '{3'd5, 5'b11111}, '{3'd5, 5'b01111}, '{3'd5, 5'b00111}, '{3'd5, 5'b00011},
        '{3'd5, 5'b00001}, '{3'd5, 5'b00000}, '{3'd5, 5'b10000}, '{3'd5, 5'b11000},
        '{3'd5, 5'b11100}, '{3'd5, 5'b11110}
    };

    localparam logic [7:0] CHAR_SPACE = 8'd32;

    // Letters of either case and digits; anything else gives length 0.
    function automatic code_t code_lookup(input logic [7:0] c);
        logic [7:0] lc;
        code_t      r;
        lc = c;
        r  = '0;
        if (c inside {[8'd65:8'd90]}) begin
            lc = c + 8'd32;
        end
        if (lc inside {[8'd97:8'd122]}) begin
            r = CODE_ROM[6'(lc - 8'd97)];
        end else if (lc inside {[8'd48:8'd57]}) begin
            r = CODE_ROM[6'(lc - 8'd48) + 6'd26];
        end
        return r;
    endfunction

endpackage

FILE: sv/text_to_morse_encoder_core.sv
// Channel   Direction  Ports                                    Content
// s_        in         s_valid s_ready s_char_code s_end_of_phrase   one ASCII byte
// m_        out        m_valid m_ready m_symbol m_last          one Morse symbol
//
// The front takes one byte a cycle while the two-entry job queue has room.
// The back loads a job only when idle, then emits one symbol a cycle unless
// m_ready stalls it: a byte gives 2*held_spaces + gap + code length + end marker
// symbols; a held space pushes no job unless it ends the phrase.
// Reset (aresetn low, synchronous) empties the queue and clears phrase state.
// Either side stalls on its own; the output register holds a valid symbol while m_ready is low.
module text_to_morse_encoder_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       s_end_of_phrase,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_symbol,
    output logic       m_last
);

    logic            q_full, q_push, q_pop, q_valid;
    tmenc_pkg::job_t push_job, pop_job;

    tmenc_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_code     (s_char_code),
        .s_end_of_phrase (s_end_of_phrase),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_job           (push_job)
    );

    tmenc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_job   (pop_job)
    );

    tmenc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_job    (pop_job),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_symbol (m_symbol),
        .m_last   (m_last)
    );

endmodule

FILE: sv/tmenc_front.sv
module tmenc_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_char_code,
    input  logic               s_end_of_phrase,
    input  logic               q_full,
    output logic               q_push,
    output tmenc_pkg::job_t    q_job
);

    logic                          started_reg, started_next;
    logic [tmenc_pkg::PEND_W-1:0]  pend_reg, pend_next;
    tmenc_pkg::code_t              code;
    logic                          accept;
    logic                          is_space;

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign is_space = (s_char_code == tmenc_pkg::CHAR_SPACE);
    assign code     = tmenc_pkg::code_lookup(s_char_code);

    always_comb begin
        started_next = started_reg;
        pend_next    = pend_reg;
        q_job        = '0;
        q_job.eop    = s_end_of_phrase;
        q_push       = 1'b0;
        if (accept) begin
            if (is_space) begin
                if (started_reg && pend_reg != tmenc_pkg::PEND_W'(tmenc_pkg::MAX_PENDING)) begin
                    pend_next = pend_reg + 1'b1;
                end
                q_push = s_end_of_phrase;
            end else begin
                q_job.pairs  = started_reg ? pend_reg : '0;
                q_job.gap    = started_reg;
                q_job.len    = code.len;
                q_job.bits   = code.bits;
                pend_next    = '0;
                started_next = 1'b1;
                q_push       = started_reg || (code.len != '0) || s_end_of_phrase;
            end
            if (s_end_of_phrase) begin
                started_next = 1'b0;
                pend_next    = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            pend_reg    <= '0;
        end else begin
            started_reg <= started_next;
            pend_reg    <= pend_next;
        end
    end

endmodule

FILE: sv/tmenc_fifo.sv
module tmenc_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  tmenc_pkg::job_t push_job,
    output logic            full,
    input  logic            pop,
    output logic            pop_valid,
    output tmenc_pkg::job_t pop_job
);

    tmenc_pkg::job_t                  mem_reg [tmenc_pkg::FIFO_DEPTH];
    logic [tmenc_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tmenc_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tmenc_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    logic                             do_push, do_pop;

    assign full      = (count_reg == tmenc_pkg::FIFO_CNT_W'(tmenc_pkg::FIFO_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_job   = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: sv/tmenc_back.sv
module tmenc_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  tmenc_pkg::job_t q_job,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [2:0]      m_symbol,
    output logic            m_last
);

    logic                              busy_reg, busy_next;
    logic [tmenc_pkg::PEND_W-1:0]      pairs_reg, pairs_next;
    logic                              half_reg, half_next;
    logic                              gap_reg, gap_next;
    logic [tmenc_pkg::CODE_LEN_W-1:0]  len_reg, len_next;
    logic [tmenc_pkg::CODE_BITS_W-1:0] bits_reg, bits_next;
    logic                              eop_reg, eop_next;
    logic                              m_valid_reg, m_valid_next;
    tmenc_pkg::sym_t                   m_symbol_reg, m_symbol_next;
    logic                              m_last_reg, m_last_next;
    logic                              adv, more;

    assign q_pop    = !busy_reg && q_valid;
    assign adv      = busy_reg && (!m_valid_reg || m_ready);
    assign m_valid  = m_valid_reg;
    assign m_symbol = m_symbol_reg;
    assign m_last   = m_last_reg;

    always_comb begin
        busy_next     = busy_reg;
        pairs_next    = pairs_reg;
        half_next     = half_reg;
        gap_next      = gap_reg;
        len_next      = len_reg;
        bits_next     = bits_reg;
        eop_next      = eop_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_symbol_next = m_symbol_reg;
        m_last_next   = m_last_reg;
        more          = 1'b0;
        if (q_pop) begin
            busy_next  = 1'b1;
            pairs_next = q_job.pairs;
            half_next  = 1'b0;
            gap_next   = q_job.gap;
            len_next   = q_job.len;
            bits_next  = q_job.bits;
            eop_next   = q_job.eop;
        end
        if (adv) begin
            if (pairs_reg != '0) begin
                if (half_reg) begin
                    m_symbol_next = tmenc_pkg::SYM_SLASH;
                    pairs_next    = pairs_reg - 1'b1;
                    half_next     = 1'b0;
                end else begin
                    m_symbol_next = tmenc_pkg::SYM_GAP;
                    half_next     = 1'b1;
                end
            end else if (gap_reg) begin
                m_symbol_next = tmenc_pkg::SYM_GAP;
                gap_next      = 1'b0;
            end else if (len_reg != '0) begin
                m_symbol_next = bits_reg[tmenc_pkg::CODE_BITS_W-1] ? tmenc_pkg::SYM_DASH
                                                                   : tmenc_pkg::SYM_DOT;
                bits_next     = {bits_reg[tmenc_pkg::CODE_BITS_W-2:0], 1'b0};
                len_next      = len_reg - 1'b1;
            end else begin
                m_symbol_next = tmenc_pkg::SYM_END;
                eop_next      = 1'b0;
            end
            more         = (pairs_next != '0) || gap_next || (len_next != '0) || eop_next;
            m_valid_next = 1'b1;
            m_last_next  = !more;
            busy_next    = more;
        end
    end

    always_ff @(posedge aclk) begin
        pairs_reg    <= pairs_next;
        half_reg     <= half_next;
        gap_reg      <= gap_next;
        len_reg      <= len_next;
        bits_reg     <= bits_next;
        eop_reg      <= eop_next;
        m_symbol_reg <= m_symbol_next;
        m_last_reg   <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: sv/tmenc_checker.sv
module tmenc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_symbol,
    input logic       m_last
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid && s_ready)
        else $error("not idle right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_symbol) && $stable(m_last))
        else $error("stalled result changed");

    a_sym_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_symbol <= 3'(tmenc_pkg::SYM_END))
        else $error("symbol code out of range");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_symbol == 3'(tmenc_pkg::SYM_END) |-> m_last)
        else $error("end marker not flagged last");

endmodule

bind text_to_morse_encoder_core tmenc_checker u_tmenc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_symbol (m_symbol),
    .m_last   (m_last)
);

FILE: sim/text_to_morse_encoder_core_tb.sv
module text_to_morse_encoder_core_tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 48;
    localparam int ITEM_TARGET = 350;
    localparam logic [7:0] SPACE = 8'd32;

    typedef struct packed {
        tmenc_pkg::sym_t sym;
        logic            last;
    } morse_res_t;

    typedef struct {
        logic [7:0] code;
        logic       eop;
        int         reps;
        bit         typed;
        string      want;
    } stim_row_t;

    // Typed rows: '.' dot, '-' dash, '/' slash, '_' gap, 'E' end marker.
    localparam int NUM_ROWS = 25;
    stim_row_t dir_rows [NUM_ROWS] = '{
        '{SPACE,  1'b0, 1,  1'b1, ""},
        '{8'd65,  1'b0, 1,  1'b1, ".-"},
        '{8'd122, 1'b0, 1,  1'b0, ""},
        '{8'd0,   1'b0, 1,  1'b1, "_"},
        '{8'd255, 1'b0, 1,  1'b1, "_"},
        '{8'd48,  1'b0, 1,  1'b1, "_-----"},
        '{8'd57,  1'b0, 1,  1'b0, ""},
        '{SPACE,  1'b0, 17, 1'b1, ""},
        '{8'd53,  1'b1, 1,  1'b0, ""},
        '{SPACE,  1'b1, 1,  1'b1, "E"},
        '{8'd101, 1'b0, 1,  1'b1, "."},
        '{SPACE,  1'b0, 2,  1'b1, ""},
        '{SPACE,  1'b1, 1,  1'b1, "E"},
        '{8'd33,  1'b1, 1,  1'b1, "E"},
        '{8'd64,  1'b0, 1,  1'b0, ""},
        '{8'd91,  1'b0, 1,  1'b0, ""},
        '{8'd96,  1'b0, 1,  1'b0, ""},
        '{8'd123, 1'b0, 1,  1'b0, ""},
        '{8'd47,  1'b0, 1,  1'b0, ""},
        '{8'd58,  1'b0, 1,  1'b0, ""},
        '{8'd90,  1'b0, 1,  1'b0, ""},
        '{SPACE,  1'b0, 1,  1'b0, ""},
        '{8'd49,  1'b1, 1,  1'b0, ""},
        '{8'd128, 1'b1, 1,  1'b1, "E"},
        '{8'd127, 1'b1, 1,  1'b0, ""}
    };

    localparam string MORSE_TBL [36] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
        ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
        "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--..",
        "-----", ".----", "..---", "...--", "....-", ".....", "-....",
        "--...", "---..", "----."
    };

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_code = 8'd0;
    logic       s_end_of_phrase = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_symbol;
    logic       m_last;

    morse_res_t symbols_due [$];
    logic       in_phrase;
    logic [3:0] spaces_held;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         n_bytes;
    int         n_phrases;
    int         n_symbols = 0;
    int         n_errors = 0;
    int         cycles = 0;

    text_to_morse_encoder_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_code     (s_char_code),
        .s_end_of_phrase (s_end_of_phrase),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_symbol        (m_symbol),
        .m_last          (m_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d symbols outstanding",
                     cycles, symbols_due.size());
            $display("text_to_morse_encoder_core_tb NOT OK");
            $finish;
        end
    end

    function automatic void encode_byte(input logic [7:0] c, input logic eop,
                                        output morse_res_t res [$]);
        logic [7:0] lc;
        int         idx;
        string      code;
        res = {};
        idx = -1;
        if (c == SPACE) begin
            if (in_phrase && spaces_held != 4'(tmenc_pkg::MAX_PENDING)) begin
                spaces_held = spaces_held + 4'd1;
            end
        end else begin
            lc = (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
            if (lc >= 8'd97 && lc <= 8'd122) begin
                idx = int'(lc) - 97;
            end else if (lc >= 8'd48 && lc <= 8'd57) begin
                idx = int'(lc) - 48 + 26;
            end
            if (in_phrase) begin
                repeat (spaces_held) begin
                    res.push_back('{tmenc_pkg::SYM_GAP, 1'b0});
                    res.push_back('{tmenc_pkg::SYM_SLASH, 1'b0});
                end
                res.push_back('{tmenc_pkg::SYM_GAP, 1'b0});
            end
            spaces_held = 4'd0;
            if (idx >= 0) begin
                code = MORSE_TBL[idx];
                for (int i = 0; i < code.len(); i++) begin
                    res.push_back('{(code[i] == "-") ? tmenc_pkg::SYM_DASH
                                                     : tmenc_pkg::SYM_DOT, 1'b0});
                end
            end
            in_phrase = 1'b1;
        end
        if (eop) begin
            res.push_back('{tmenc_pkg::SYM_END, 1'b0});
            in_phrase = 1'b0;
            spaces_held = 4'd0;
        end
        if (res.size() > 0) begin
            res[res.size()-1].last = 1'b1;
        end
    endfunction

    function automatic void parse_typed(input string s, output morse_res_t res [$]);
        tmenc_pkg::sym_t sym;
        res = {};
        for (int i = 0; i < s.len(); i++) begin
            case (s[i])
                "-": sym = tmenc_pkg::SYM_DASH;
                "/": sym = tmenc_pkg::SYM_SLASH;
                "_": sym = tmenc_pkg::SYM_GAP;
                "E": sym = tmenc_pkg::SYM_END;
                default: sym = tmenc_pkg::SYM_DOT;
            endcase
            res.push_back('{sym, (i == s.len() - 1)});
        end
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic eop,
                             input bit typed, input string want);
        morse_res_t pred [$];
        morse_res_t fixed [$];
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_char_code <= c;
        s_end_of_phrase <= eop;
        do @(posedge aclk); while (!s_ready);
        encode_byte(c, eop, pred);
        if (typed) begin
            parse_typed(want, fixed);
            pred = fixed;
        end
        foreach (pred[i]) symbols_due.push_back(pred[i]);
        n_bytes++;
        if (eop) n_phrases++;
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            return 8'(($urandom_range(0, 1) ? 65 : 97) + $urandom_range(0, 25));
        end else if (r < 50) begin
            return 8'(48 + $urandom_range(0, 9));
        end else if (r < 78) begin
            return SPACE;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly ordinary phrases; some all-space phrases and long space runs.
    task automatic send_random_phrase();
        int len;
        int kind;
        int run_at;
        len = $urandom_range(1, 12);
        kind = $urandom_range(0, 99);
        run_at = (kind >= 8 && kind < 18) ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++) begin
            if (i == run_at) begin
                repeat ($urandom_range(13, 18)) send_byte(SPACE, 1'b0, 1'b0, "");
            end
            send_byte((kind < 8) ? SPACE : pick_byte(), (i == len - 1), 1'b0, "");
        end
    endtask

    always @(posedge aclk) begin
        morse_res_t want;
        if (aresetn && m_valid && m_ready) begin
            n_symbols++;
            if (symbols_due.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("unexpected item: symbol %0d last %0b", m_symbol, m_last);
                end
            end else begin
                want = symbols_due.pop_front();
                if (m_symbol !== want.sym || m_last !== want.last) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("item %0d: expected symbol %0d last %0b, got %0d %0b",
                                 n_symbols, want.sym, want.last, m_symbol, m_last);
                    end
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        int idle_tbl [4];
        int stall_tbl [4];
        idle_tbl = '{0, 77, 0, 38};
        stall_tbl = '{0, 0, 77, 38};
        n_bytes = 0;
        n_phrases = 0;
        in_phrase = 1'b0;
        spaces_held = 4'd0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[r]) begin
            repeat (dir_rows[r].reps) begin
                send_byte(dir_rows[r].code, dir_rows[r].eop, dir_rows[r].typed,
                          dir_rows[r].want);
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_tbl[ph];
            recv_stall_pct = stall_tbl[ph];
            while (n_bytes < (ph + 1) * ITEM_TARGET / 4) send_random_phrase();
        end
        s_valid <= 1'b0;

        while (symbols_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("sent %0d bytes in %0d phrases under four handshake pressure phases",
                 n_bytes, n_phrases);
        $display("checked %0d Morse symbols, %0d mismatches", n_symbols, n_errors);
        if (n_errors == 0) begin
            $display("text_to_morse_encoder_core_tb OK");
        end else begin
            $display("text_to_morse_encoder_core_tb NOT OK");
        end
        $finish;
    end

endmodule
